// File: design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and event codes for the checked frame receiver FIFO core.
// ----------------------------------------------------------------------------
package cfr_pkg;

    typedef logic [2:0] t_event;

    // Result event codes
    localparam t_event EV_NONE       = 3'd0;
    localparam t_event EV_FRAME_OK   = 3'd1;
    localparam t_event EV_BAD_START  = 3'd2;
    localparam t_event EV_BAD_LENGTH = 3'd3;
    localparam t_event EV_BAD_CHKSUM = 3'd4;
    localparam t_event EV_POP_EMPTY  = 3'd5;

    // Operation codes of an input beat
    localparam logic OP_RX  = 1'b0;
    localparam logic OP_POP = 1'b1;

    // Start byte value after reset
    localparam logic [7:0] START_BYTE_RESET = 8'd17;

    // Drop tally saturates here
    localparam logic [6:0] DROP_MAX = 7'd127;

endpackage

// File: design/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held until the next read enable
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/checked_frame_receiver_fifo_core.sv
// ----------------------------------------------------------------------------
// checked_frame_receiver_fifo_core
// Receives length-prefixed frames with an 8-bit sum checksum into a byte
// ring, commits data on a good checksum, clears on errors, and serves pops.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-----------------------------------
//  input   | in        | i_valid / o_ready   | i_op, i_rx_byte
//  result  | out       | o_valid / i_ready   | o_event_res, o_dropped_count,
//          |           |                     | o_pop_byte, o_pop_valid, o_not_empty
//  config  | in        | i_cfg_we            | i_cfg_wdata (start byte)
//
//  One beat in per cycle while o_ready is high; its result appears in the cycle after acceptance.
//  Latency is set by the result register and the registered RAM read port.
//  o_ready is high when the result register is empty or is being taken.
//  A stalled result holds; the input stalls only while the result is unread.
//  Synchronous active-low reset; the ring contents are not cleared.
//
module checked_frame_receiver_fifo_core #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    // input beats
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic [7:0]           i_rx_byte,
    // result beats
    output logic                 o_valid,
    input  logic                 i_ready,
    output cfr_pkg::t_event      o_event_res,
    output logic [6:0]           o_dropped_count,
    output logic [7:0]           o_pop_byte,
    output logic                 o_pop_valid,
    output logic                 o_not_empty
);

    import cfr_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
    localparam logic [8:0]    MAX_LEN   = 9'(FIFO_DEPTH);

    // Frame phase codes
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_SUM   = 2'd3;

    logic [7:0]    r_start_byte;
    logic [1:0]    r_phase,    n_phase;
    logic [7:0]    r_left,     n_left;
    logic [7:0]    r_sum,      n_sum;
    logic [AW-1:0] r_head,     n_head;
    logic [AW-1:0] r_tail,     n_tail;
    logic [AW-1:0] r_thead,    n_thead;
    logic [6:0]    r_drops,    n_drops;

    logic          r_out_valid;
    t_event        r_event,    n_event;
    logic [6:0]    r_dropped,  n_dropped;
    logic          r_pvalid,   n_pvalid;
    logic          r_nempty;

    logic          accept;
    logic [AW-1:0] tail_nx;
    logic [AW-1:0] thead_nx;
    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign tail_nx  = next_slot(r_tail);
    assign thead_nx = next_slot(r_thead);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RESET;
        end else if (i_cfg_we) begin
            r_start_byte <= i_cfg_wdata;
        end
    end

    // Next state and result for the beat at the input
    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_sum     = r_sum;
        n_head    = r_head;
        n_tail    = r_tail;
        n_thead   = r_thead;
        n_drops   = r_drops;
        n_event   = EV_NONE;
        n_dropped = '0;
        n_pvalid  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;

        if (i_op == OP_POP) begin
            // Pop the oldest committed byte
            if (r_tail == r_head) begin
                n_event = EV_POP_EMPTY;
            end else begin
                n_tail   = tail_nx;
                n_pvalid = 1'b1;
                ram_re   = accept;
            end
        end else begin
            case (r_phase)
                PH_START: begin
                    if (i_rx_byte != r_start_byte) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_thead = '0;
                        n_event = EV_BAD_START;
                    end else begin
                        n_sum   = i_rx_byte;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (i_rx_byte == 8'd0 || {1'b0, i_rx_byte} > MAX_LEN) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_thead = '0;
                        n_phase = PH_START;
                        n_event = EV_BAD_LENGTH;
                    end else begin
                        n_left  = i_rx_byte;
                        n_sum   = r_sum + i_rx_byte;
                        n_thead = r_head;
                        n_drops = '0;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    // Write tentatively past the head, or drop when full
                    n_sum = r_sum + i_rx_byte;
                    if (thead_nx == r_tail) begin
                        if (r_drops != DROP_MAX) begin
                            n_drops = r_drops + 7'd1;
                        end
                    end else begin
                        n_thead = thead_nx;
                        ram_we  = accept;
                    end
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_SUM;
                    end
                end
                default: begin
                    // Checksum: commit or clear
                    if (i_rx_byte == r_sum) begin
                        n_head    = r_thead;
                        n_event   = EV_FRAME_OK;
                        n_dropped = r_drops;
                    end else begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_thead = '0;
                        n_event = EV_BAD_CHKSUM;
                    end
                    n_phase = PH_START;
                end
            endcase
        end
    end

    // Frame and pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_left  <= '0;
            r_sum   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_thead <= '0;
            r_drops <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_sum   <= n_sum;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_thead <= n_thead;
            r_drops <= n_drops;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event   <= n_event;
            r_dropped <= n_dropped;
            r_pvalid  <= n_pvalid;
            r_nempty  <= (n_tail != n_head);
        end
    end

    // Byte ring
    cfr_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (thead_nx),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (tail_nx),
        .o_rdata (ram_rdata)
    );

    assign o_valid         = r_out_valid;
    assign o_event_res     = r_event;
    assign o_dropped_count = r_dropped;
    assign o_pop_valid     = r_pvalid;
    assign o_pop_byte      = r_pvalid ? ram_rdata : 8'd0;
    assign o_not_empty     = r_nempty;

endmodule

// File: design/cfr_checker.sv
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks on the result beats of the frame receiver FIFO core.
// ----------------------------------------------------------------------------
module cfr_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_valid,
    input  cfr_pkg::t_event o_event_res,
    input  logic [6:0]      o_dropped_count,
    input  logic [7:0]      o_pop_byte,
    input  logic            o_pop_valid,
    input  logic            o_not_empty
);

    import cfr_pkg::*;

    // A real popped byte comes with no frame event
    a_pop_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pop_valid |-> o_event_res == EV_NONE)
        else $error("pop beat carries a frame event");

    // Drops are reported only with a good frame
    a_drops_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res != EV_FRAME_OK |-> o_dropped_count == 7'd0)
        else $error("drop count outside a good frame");

    // A beat without a popped byte, such as an empty pop, returns zero
    a_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pop_valid |-> o_pop_byte == 8'd0)
        else $error("pop byte nonzero without a popped byte");

    // Errors clear the FIFO, and an empty pop leaves it empty
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_BAD_START || o_event_res == EV_BAD_LENGTH ||
                    o_event_res == EV_BAD_CHKSUM || o_event_res == EV_POP_EMPTY)
        |-> !o_not_empty)
        else $error("FIFO not empty after clear or empty pop");

endmodule

bind checked_frame_receiver_fifo_core cfr_checker u_cfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .o_event_res     (o_event_res),
    .o_dropped_count (o_dropped_count),
    .o_pop_byte      (o_pop_byte),
    .o_pop_valid     (o_pop_valid),
    .o_not_empty     (o_not_empty)
);
